FILE: rtl/alarm_table_priority_tracker_defines.svh
// Assertion macros for the alarm table priority tracker checker.
`ifndef ALARM_TABLE_PRIORITY_TRACKER_DEFINES_SVH
`define ALARM_TABLE_PRIORITY_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/atpt_pkg.sv
`timescale 1ns / 1ps

package atpt_pkg;

    localparam int CATALOG_DEPTH = 64;
    localparam int ADDR_W        = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(CATALOG_DEPTH + 1);

    localparam logic [2:0] OP_TRIGGER    = 3'd0;
    localparam logic [2:0] OP_CLEAR      = 3'd1;
    localparam logic [2:0] OP_LOAD_START = 3'd2;
    localparam logic [2:0] OP_LOAD_ENTRY = 3'd3;
    localparam logic [2:0] OP_STATUS     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARAM    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    localparam logic [1:0] LVL_CRITICAL = 2'd2;

    localparam logic [1:0] SAFE_OK      = 2'd0;
    localparam logic [1:0] SAFE_WARNING = 2'd1;
    localparam logic [1:0] SAFE_LOCKOUT = 2'd2;

    // Rank is level plus one; zero means nothing active.
    localparam logic [1:0] RANK_MAJOR    = 2'd2;
    localparam logic [1:0] RANK_CRITICAL = 2'd3;

    typedef struct packed {
        logic [31:0] code;
        logic [1:0]  level;
    } cat_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        cat_entry_t        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  event_kind;
        logic [31:0] event_code;
        logic [1:0]  safety_state;
        logic [31:0] top_code;
    } result_t;

endpackage

FILE: rtl/atpt_catalog_mem.sv
`timescale 1ns / 1ps

module atpt_catalog_mem
    import atpt_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output cat_entry_t rd_data
);

    cat_entry_t mem [CATALOG_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: rtl/atpt_engine.sv
`timescale 1ns / 1ps

module atpt_engine
    import atpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  opcode,
    input  logic [31:0] cmd_code,
    input  logic [1:0]  entry_level,
    input  logic [9:0]  entry_index,
    input  logic [10:0] entry_total,
    output logic        busy,
    output mem_req_t    mem_req,
    input  cat_entry_t  mem_rd_data,
    output logic        res_valid,
    output result_t     res
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;

    logic [1:0]               state_reg,  state_next;
    logic [COUNT_W-1:0]       count_reg,  count_next;
    logic [CATALOG_DEPTH-1:0] flags_reg,  flags_next;
    logic [COUNT_W-1:0]       ptr_reg,    ptr_next;
    logic                     pend_reg,   pend_next;
    logic [ADDR_W-1:0]        pidx_reg,   pidx_next;
    logic [31:0]              code_reg,   code_next;
    logic                     want_reg,   want_next;
    logic [1:0]               status_reg, status_next;
    logic [1:0]               evk_reg,    evk_next;
    logic [31:0]              evc_reg,    evc_next;
    logic [1:0]               best_reg,   best_next;
    logic [31:0]              top_reg,    top_next;

    logic       accept;
    logic       rd_en;
    logic       sweep_end;
    logic [1:0] rank;

    assign accept    = start && (state_reg == S_IDLE);
    assign rd_en     = (state_reg != S_IDLE) && (ptr_reg < count_reg);
    assign sweep_end = !pend_reg && !rd_en;
    assign rank      = mem_rd_data.level + 2'd1;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        mem_req.rd_en         = rd_en;
        mem_req.rd_addr       = ptr_reg[ADDR_W-1:0];
        mem_req.wr_addr       = entry_index[ADDR_W-1:0];
        mem_req.wr_data.code  = cmd_code;
        mem_req.wr_data.level = entry_level;
        mem_req.wr_en         = accept && (opcode == OP_LOAD_ENTRY)
                                && (32'(entry_index) < CATALOG_DEPTH)
                                && (entry_level <= LVL_CRITICAL);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        flags_next  = flags_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        code_next   = code_reg;
        want_next   = want_reg;
        status_next = status_reg;
        evk_next    = evk_reg;
        evc_next    = evc_reg;
        best_next   = best_reg;
        top_next    = top_reg;
        res_valid   = 1'b0;

        res.status       = status_reg;
        res.event_kind   = evk_reg;
        res.event_code   = evc_reg;
        res.top_code     = top_reg;
        res.safety_state = (best_reg == RANK_CRITICAL) ? SAFE_LOCKOUT :
                           (best_reg == RANK_MAJOR)    ? SAFE_WARNING : SAFE_OK;

        // Advance the read sweep in either search or scan.
        if (rd_en)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        pend_next = rd_en;
        pidx_next = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next   = cmd_code;
                    want_next   = (opcode == OP_TRIGGER);
                    status_next = ST_OK;
                    evk_next    = EV_NONE;
                    evc_next    = 32'd0;
                    best_next   = 2'd0;
                    top_next    = 32'd0;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCAN;
                    case (opcode)
                        OP_TRIGGER, OP_CLEAR:
                        begin
                            state_next = S_SEARCH;
                        end
                        OP_LOAD_START:
                        begin
                            if (32'(entry_total) > CATALOG_DEPTH)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                count_next = entry_total[COUNT_W-1:0];
                                flags_next = '0;
                            end
                        end
                        OP_LOAD_ENTRY:
                        begin
                            if (!mem_req.wr_en)
                            begin
                                status_next = ST_PARAM;
                            end
                        end
                        OP_STATUS:
                        begin
                        end
                        default:
                        begin
                            status_next = ST_PARAM;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (pend_reg && (mem_rd_data.code == code_reg))
                begin
                    flags_next[pidx_reg] = want_reg;
                    if (flags_reg[pidx_reg] != want_reg)
                    begin
                        evk_next = want_reg ? EV_ON : EV_OFF;
                        evc_next = code_reg;
                    end
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
                else if (sweep_end)
                begin
                    status_next = ST_PARAM;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && flags_reg[pidx_reg] && (rank > best_reg))
                begin
                    best_next = rank;
                    top_next  = mem_rd_data.code;
                end
                if (sweep_end)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            flags_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        code_reg   <= code_next;
        want_reg   <= want_next;
        status_reg <= status_next;
        evk_reg    <= evk_next;
        evc_reg    <= evc_next;
        best_reg   <= best_next;
        top_reg    <= top_next;
    end

endmodule

FILE: rtl/alarm_table_priority_tracker.sv
// Sequence, n = entry count: status reads and loads run only the priority scan over the n
//   entries; trigger and clear first search the slots in order for the code, then scan,
//   and a search with no match sweeps all n slots. An empty catalog reads no slot.
// Throughput: one transaction at a time; busy falls as the result is registered, so the next
//   is accepted at the earliest at the edge that ends the done cycle; sweeps share one port.
// Reset: rst_n clears count and flags, catalog undefined until loaded; done strobes, no stall.
`timescale 1ns / 1ps

module alarm_table_priority_tracker
    import atpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] cmd_code,
    input  logic [1:0]  entry_level,
    input  logic [9:0]  entry_index,
    input  logic [10:0] entry_total,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  event_kind,
    output logic [31:0] event_code,
    output logic [1:0]  safety_state,
    output logic [31:0] top_code
);

    // The catalog memory holds code and level per slot; active flags and the entry
    // count live in flip-flops in the engine so that load start can clear them at once.
    // Writes happen only at acceptance, never during a sweep, so reads and writes of
    // the same slot cannot overlap and need no forwarding.

    mem_req_t   mem_req;
    cat_entry_t mem_rd_data;
    logic       res_valid;
    result_t    res;

    logic    done_reg;
    result_t res_reg;

    atpt_catalog_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Run the lookup sweep (trigger/clear only), then the priority scan.
    atpt_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .cmd_code    (cmd_code),
        .entry_level (entry_level),
        .entry_index (entry_index),
        .entry_total (entry_total),
        .busy        (busy),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Hold the finished result in an output register for its single strobe cycle,
    // so the engine is already free for the next transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign done         = done_reg;
    assign status       = res_reg.status;
    assign event_kind   = res_reg.event_kind;
    assign event_code   = res_reg.event_code;
    assign safety_state = res_reg.safety_state;
    assign top_code     = res_reg.top_code;

endmodule

FILE: rtl/atpt_checker.sv
`timescale 1ns / 1ps
`include "alarm_table_priority_tracker_defines.svh"

module atpt_checker
    import atpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [1:0]  event_kind,
    input logic [31:0] event_code
);

    `ATPT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `ATPT_ASSERT_IMP(a_busy_fall_done, $fell(busy), done, "busy fell without a result")
    `ATPT_ASSERT_NXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
    `ATPT_ASSERT_IMP(a_no_event_code, done && (event_kind == EV_NONE), event_code == 32'd0, "event code set without event")
    `ATPT_ASSERT_IMP(a_event_ok, done && (event_kind != EV_NONE), status == ST_OK, "event reported with error status")

endmodule

bind alarm_table_priority_tracker atpt_checker u_atpt_checker (.*);

FILE: dv/alarm_table_priority_tracker_checker.sv
`timescale 1ns / 1ps

module alarm_table_priority_tracker_checker
    import atpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] cmd_code,
    input  logic [1:0]  entry_level,
    input  logic [9:0]  entry_index,
    input  logic [10:0] entry_total,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [1:0]  event_kind,
    input  logic [31:0] event_code,
    input  logic [1:0]  safety_state,
    input  logic [31:0] top_code,
    output int          fail_count,
    output int          outstanding,
    output int          reports_seen,
    output int          flips_seen
);

    // Shadow of the alarm catalog
    logic [31:0] cat_code  [CATALOG_DEPTH];
    logic [1:0]  cat_level [CATALOG_DEPTH];
    bit          alarm_on  [CATALOG_DEPTH];
    int          live_count;

    result_t     awaited_reports [$];
    result_t     got;
    result_t     want;
    int          faults;
    int          seen;
    int          flips;

    // Apply one command to the shadow catalog and return the report it earns.
    function automatic result_t apply_command(input logic [2:0]  op,
                                              input logic [31:0] code,
                                              input logic [1:0]  lvl,
                                              input logic [9:0]  idx,
                                              input logic [10:0] tot);
        result_t r;
        int      hit;
        int      best;
        int      i;
        r   = '0;
        hit = -1;
        case (op)
            OP_TRIGGER, OP_CLEAR:
            begin
                for (i = 0; i < live_count; i++)
                begin
                    if (hit < 0 && cat_code[i] == code)
                        hit = i;
                end
                if (hit < 0)
                    r.status = ST_PARAM;
                else if (alarm_on[hit] != (op == OP_TRIGGER))
                begin
                    alarm_on[hit] = (op == OP_TRIGGER);
                    r.event_kind  = (op == OP_TRIGGER) ? EV_ON : EV_OFF;
                    r.event_code  = code;
                end
            end
            OP_LOAD_START:
            begin
                if (tot > CATALOG_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    live_count = int'(tot);
                    foreach (alarm_on[j])
                        alarm_on[j] = 1'b0;
                end
            end
            OP_LOAD_ENTRY:
            begin
                if (idx >= CATALOG_DEPTH || lvl > LVL_CRITICAL)
                    r.status = ST_PARAM;
                else
                begin
                    cat_code[idx[ADDR_W-1:0]]  = code;
                    cat_level[idx[ADDR_W-1:0]] = lvl;
                end
            end
            OP_STATUS: ;
            default:
                r.status = ST_PARAM;
        endcase

        best = 0;
        for (i = 0; i < live_count; i++)
        begin
            if (alarm_on[i] && int'(cat_level[i]) + 1 > best)
            begin
                best       = int'(cat_level[i]) + 1;
                r.top_code = cat_code[i];
            end
        end
        if (best == int'(RANK_CRITICAL))
            r.safety_state = SAFE_LOCKOUT;
        else if (best == int'(RANK_MAJOR))
            r.safety_state = SAFE_WARNING;
        else
            r.safety_state = SAFE_OK;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            awaited_reports.delete();
            live_count = 0;
            foreach (alarm_on[i])
                alarm_on[i] = 1'b0;
            faults = 0;
            seen   = 0;
            flips  = 0;
        end
        else
        begin
            // A report leaves before any transaction accepted on the same edge
            if (done)
            begin
                seen++;
                got = {status, event_kind, event_code, safety_state, top_code};
                if (awaited_reports.size() == 0)
                begin
                    if (faults < 10)
                        $display("%0t: unexpected report status=%0d event=%0d/%h safety=%0d top=%h",
                                 $time, got.status, got.event_kind, got.event_code,
                                 got.safety_state, got.top_code);
                    faults++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (want.event_kind != EV_NONE)
                        flips++;
                    if (got.status !== want.status || got.event_kind !== want.event_kind ||
                        got.event_code !== want.event_code ||
                        got.safety_state !== want.safety_state ||
                        got.top_code !== want.top_code)
                    begin
                        if (faults < 10)
                        begin
                            $display("%0t: report %0d differs", $time, seen);
                            $display("    expected status=%0d event=%0d/%h safety=%0d top=%h",
                                     want.status, want.event_kind, want.event_code,
                                     want.safety_state, want.top_code);
                            $display("    actual   status=%0d event=%0d/%h safety=%0d top=%h",
                                     got.status, got.event_kind, got.event_code,
                                     got.safety_state, got.top_code);
                        end
                        faults++;
                    end
                end
            end
            if (start && !busy)
                awaited_reports.push_back(apply_command(opcode, cmd_code, entry_level,
                                                        entry_index, entry_total));
        end
        fail_count   <= faults;
        outstanding  <= awaited_reports.size();
        reports_seen <= seen;
        flips_seen   <= flips;
    end

endmodule

FILE: dv/alarm_table_priority_tracker_tb.sv
`timescale 1ns / 1ps

module alarm_table_priority_tracker_tb;
    import atpt_pkg::*;

    localparam int         ITEM_TARGET    = 1500;
    // Commands in this window go back to back, with no idle gaps inserted between them
    localparam int         QUIET_FROM     = 700;
    localparam int         QUIET_TO       = 1000;
    localparam int         DRAIN_CYCLES   = 2 * CATALOG_DEPTH + 20;
    localparam int         INDEX_MAX      = 1023;
    localparam int         TOTAL_MAX      = 1024;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [1:0] LVL_MINOR      = 2'd0;
    localparam logic [1:0] LVL_MAJOR      = 2'd1;
    localparam logic [1:0] LVL_BAD        = 2'd3;

    // Every input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  opcode      = OP_STATUS;
    logic [31:0] cmd_code    = '0;
    logic [1:0]  entry_level = LVL_MINOR;
    logic [9:0]  entry_index = '0;
    logic [10:0] entry_total = '0;

    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [1:0]  event_kind;
    logic [31:0] event_code;
    logic [1:0]  safety_state;
    logic [31:0] top_code;

    int          fail_count;
    int          outstanding;
    int          reports_seen;
    int          flips_seen;

    // Stimulus bookkeeping: which slots hold a definition, and with what code.
    // A load start may only announce a count covering written slots, so the
    // block never sweeps over an entry that was never loaded.
    bit          slot_written [CATALOG_DEPTH];
    logic [31:0] slot_code    [CATALOG_DEPTH];
    int          sent;
    int          sessions;

    always #4 clk = ~clk;

    alarm_table_priority_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .cmd_code     (cmd_code),
        .entry_level  (entry_level),
        .entry_index  (entry_index),
        .entry_total  (entry_total),
        .done         (done),
        .status       (status),
        .event_kind   (event_kind),
        .event_code   (event_code),
        .safety_state (safety_state),
        .top_code     (top_code)
    );

    alarm_table_priority_tracker_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .cmd_code     (cmd_code),
        .entry_level  (entry_level),
        .entry_index  (entry_index),
        .entry_total  (entry_total),
        .done         (done),
        .status       (status),
        .event_kind   (event_kind),
        .event_code   (event_code),
        .safety_state (safety_state),
        .top_code     (top_code),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .reports_seen (reports_seen),
        .flips_seen   (flips_seen)
    );

    // Draw an alarm code: the extremes, a small shared pool so that duplicate
    // codes appear in one catalog, or anything at all.
    function automatic logic [31:0] pick_code(input int pool);
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(1, pool);
            default: return $urandom;
        endcase
    endfunction

    // Drive one transaction, entered and left at a falling edge. Fields the
    // opcode does not use carry random values, which the block must ignore.
    task automatic issue(input logic [2:0]  op,
                         input logic [31:0] code,
                         input logic [1:0]  lvl,
                         input logic [9:0]  idx,
                         input logic [10:0] tot);
        logic [31:0] c;
        logic [1:0]  l;
        logic [9:0]  x;
        logic [10:0] t;
        int          gap;
        c = code;
        l = lvl;
        x = idx;
        t = tot;
        if (op != OP_TRIGGER && op != OP_CLEAR && op != OP_LOAD_ENTRY)
            c = $urandom;
        if (op != OP_LOAD_ENTRY)
        begin
            l = 2'($urandom_range(0, 3));
            x = 10'($urandom_range(0, INDEX_MAX));
        end
        if (op != OP_LOAD_START)
            t = 11'($urandom_range(0, TOTAL_MAX));

        // Idle for a while now and then; start low, junk on the fields
        if ((sent < QUIET_FROM || sent >= QUIET_TO) && $urandom_range(0, 99) < 27)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 150) : $urandom_range(1, 12);
            start       <= 1'b0;
            opcode      <= 3'($urandom_range(0, 7));
            cmd_code    <= $urandom;
            entry_level <= 2'($urandom_range(0, 3));
            entry_index <= 10'($urandom_range(0, INDEX_MAX));
            entry_total <= 11'($urandom_range(0, TOTAL_MAX));
            repeat (gap) @(negedge clk);
        end

        start       <= 1'b1;
        opcode      <= op;
        cmd_code    <= c;
        entry_level <= l;
        entry_index <= x;
        entry_total <= t;
        // Hold the command until an edge finds busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);

        if (op == OP_LOAD_ENTRY && x < CATALOG_DEPTH && l <= LVL_CRITICAL)
        begin
            slot_written[x[ADDR_W-1:0]] = 1'b1;
            slot_code[x[ADDR_W-1:0]]    = c;
        end
        sent++;
    endtask

    // One stray or malformed command: unused opcodes, oversize counts,
    // indexes and levels out of range, plain reads, odd loads and recounts.
    task automatic poke_noise(input int pool);
        int prefix;
        prefix = 0;
        while (prefix < CATALOG_DEPTH && slot_written[prefix])
            prefix++;
        case ($urandom_range(0, 6))
            0: issue(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom, '0, '0, '0);
            1: issue(OP_LOAD_START, '0, '0, '0,
                     11'($urandom_range(CATALOG_DEPTH + 1, TOTAL_MAX)));
            2: issue(OP_LOAD_ENTRY, pick_code(pool), 2'($urandom_range(0, 3)),
                     10'($urandom_range(CATALOG_DEPTH, INDEX_MAX)), '0);
            3: issue(OP_LOAD_ENTRY, pick_code(pool), LVL_BAD,
                     10'($urandom_range(0, INDEX_MAX)), '0);
            4: issue(OP_STATUS, '0, '0, '0, '0);
            5: issue(OP_LOAD_ENTRY, pick_code(pool), 2'($urandom_range(0, LVL_CRITICAL)),
                     10'($urandom_range(0, CATALOG_DEPTH - 1)), '0);
            default: issue(OP_LOAD_START, '0, '0, '0, 11'($urandom_range(0, prefix)));
        endcase
    endtask

    initial
    begin : stimulus
        int n;
        int pool;
        int ops;
        int k;
        logic [2:0] op;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty catalog, extremes and every corner of the scheme
        issue(OP_STATUS, '0, '0, '0, '0);
        issue(OP_TRIGGER, 32'h0000_0000, '0, '0, '0);
        issue(OP_LOAD_START, '0, '0, '0, 11'd0);
        issue(OP_LOAD_ENTRY, 32'hFFFF_FFFF, LVL_CRITICAL, 10'd0, '0);
        issue(OP_LOAD_ENTRY, 32'h0000_0000, LVL_MAJOR, 10'd1, '0);
        issue(OP_LOAD_ENTRY, 32'h8000_0001, LVL_MINOR, 10'd2, '0);
        // Duplicate code further down: searches must stop at the first one
        issue(OP_LOAD_ENTRY, 32'hFFFF_FFFF, LVL_MINOR, 10'd3, '0);
        issue(OP_LOAD_ENTRY, 32'hDEAD_BEEF, LVL_MAJOR, 10'(INDEX_MAX), '0);
        issue(OP_LOAD_ENTRY, 32'hDEAD_BEEF, LVL_MAJOR, 10'(CATALOG_DEPTH), '0);
        issue(OP_LOAD_ENTRY, 32'h0BAD_0BAD, LVL_BAD, 10'd5, '0);
        issue(OP_LOAD_START, '0, '0, '0, 11'(TOTAL_MAX));
        issue(OP_LOAD_START, '0, '0, '0, 11'(CATALOG_DEPTH + 1));
        issue(OP_LOAD_START, '0, '0, '0, 11'd4);
        issue(OP_TRIGGER, 32'h8000_0001, '0, '0, '0);
        issue(OP_TRIGGER, 32'h0000_0000, '0, '0, '0);
        issue(OP_TRIGGER, 32'h0000_0000, '0, '0, '0);
        issue(OP_TRIGGER, 32'hFFFF_FFFF, '0, '0, '0);
        issue(OP_TRIGGER, 32'h1234_5678, '0, '0, '0);
        for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            issue(3'(k), 32'hFFFF_FFFF, '0, '0, '0);
        issue(OP_CLEAR, 32'hFFFF_FFFF, '0, '0, '0);
        issue(OP_CLEAR, 32'hFFFF_FFFF, '0, '0, '0);
        // Loaded above the count: invisible to searches
        issue(OP_LOAD_ENTRY, 32'h5555_AAAA, LVL_CRITICAL, 10'(CATALOG_DEPTH - 1), '0);
        issue(OP_TRIGGER, 32'h5555_AAAA, '0, '0, '0);
        issue(OP_LOAD_START, '0, '0, '0, 11'd4);

        // Random sessions: load a catalog, announce it, then work the alarms.
        // Most catalogs are small; a few fill every slot.
        while (sent < ITEM_TARGET)
        begin
            sessions++;
            case ($urandom_range(0, 9))
                0:       n = CATALOG_DEPTH;
                1:       n = $urandom_range(13, CATALOG_DEPTH - 1);
                default: n = $urandom_range(1, 12);
            endcase
            pool = $urandom_range(1, n);

            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    poke_noise(pool);
                issue(OP_LOAD_ENTRY, pick_code(pool), 2'($urandom_range(0, LVL_CRITICAL)),
                      10'(k), '0);
            end
            issue(OP_LOAD_START, '0, '0, '0, 11'(n));

            ops = $urandom_range(n, 3 * n + 6);
            for (k = 0; k < ops; k++)
            begin
                case ($urandom_range(0, 19))
                    0: poke_noise(pool);
                    1: issue(OP_STATUS, '0, '0, '0, '0);
                    // Mostly unknown codes
                    2: issue(($urandom_range(0, 1) == 0) ? OP_TRIGGER : OP_CLEAR, $urandom,
                             '0, '0, '0);
                    // Redefine a live slot while alarms may be up
                    3: issue(OP_LOAD_ENTRY, pick_code(pool), 2'($urandom_range(0, LVL_CRITICAL)),
                             10'($urandom_range(0, n - 1)), '0);
                    default:
                    begin
                        op = ($urandom_range(0, 9) < 6) ? OP_TRIGGER : OP_CLEAR;
                        issue(op, slot_code[$urandom_range(0, n - 1)], '0, '0, '0);
                    end
                endcase
            end
        end
        start <= 1'b0;

        // Drain: wait for every report, then a margin for strays
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands over %0d catalog sessions; %0d reports checked, %0d alarm flips",
                 sent, sessions, reports_seen, flips_seen);
        $display("Mismatching or stray reports: %0d", fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run well past the slowest legal one
    initial
    begin : watchdog
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/atpt_pkg.sv
rtl/atpt_catalog_mem.sv
rtl/atpt_engine.sv
rtl/alarm_table_priority_tracker.sv
rtl/atpt_checker.sv
dv/alarm_table_priority_tracker_checker.sv
dv/alarm_table_priority_tracker_tb.sv
